// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Check that the consequence holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== design/mhkv_pkg.sv =====
// Package: constants, opcodes and hash helpers for the key/value table
package mhkv_pkg;
    localparam int NUM_BUCKETS_DEF  = 256;
    localparam int WAYS_DEF         = 4;
    localparam logic [31:0] HASH_SEED = 32'hDEADBEEF;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    typedef logic [1:0] t_op;
    localparam t_op OP_GET = 2'd0;
    localparam t_op OP_PUT = 2'd1;
    localparam t_op OP_DEL = 2'd2;
    localparam t_op OP_NOP = 2'd3;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction
endpackage

// ===== design/murmur_hashed_key_value_table.sv =====
// Top level: hashed key/value table with bucket memories and read-modify-write
//  channel | valid       | ready       | payload
//  request | i_valid     | o_ready     | i_op, i_key, i_value
//  result  | o_valid     | i_ready     | o_found, o_read_value, o_bucket_full
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_data
// A request passes through accept, 8 hash steps, 2 reduce steps, a bucket
// read and a bucket update; the result is raised together with the update, and a
// new request is taken only once the sequencer is back in idle.
// Reset is synchronous; a clearing pass then empties the valid memory one bucket
// per cycle (256 buckets by default) while o_ready stays low.
// A stalled result holds while the next request is taken, hashed and read; its
// update then waits until the stalled result is accepted.
module murmur_hashed_key_value_table import mhkv_pkg::*; #(
    parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
    parameter int WAYS_PER_BUCKET = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [63:0] o_read_value,
    output logic        o_bucket_full,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
`include "assert_macros.svh"
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int HL = 7;
    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    localparam logic [63:0] RECIP = IS_POW2 ? 64'd0 : ((64'd1 << 32) / 64'(NUM_BUCKETS));

    localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2, S_RED = 3'd3,
                           S_READ = 3'd4, S_MOD = 3'd5;

    logic [2:0]  r_state;
    logic [2:0]  r_cnt;
    logic [3:0]  r_bits;
    t_op         r_op;
    logic [63:0] r_key, r_val;
    logic [BW-1:0] r_bkt;
    logic [BW-1:0] r_clr;
    logic [15:0] r_mh, r_q;
    logic [31:0] hash;
    logic        adv;
    logic        mod_go;

    logic [WAYS_PER_BUCKET*64-1:0] mem_k [NUM_BUCKETS];
    logic [WAYS_PER_BUCKET*64-1:0] mem_v [NUM_BUCKETS];
    logic [WAYS_PER_BUCKET-1:0]    mem_vld [NUM_BUCKETS];
    logic [WAYS_PER_BUCKET*64-1:0] r_rk, r_rv;
    logic [WAYS_PER_BUCKET-1:0]    r_rvld;
    logic [WAYS_PER_BUCKET-1:0]    vld_upd;

    mhkv_hash u_hash (.i_clk(i_clk), .i_adv(adv), .i_key(r_key), .o_hash(hash));

    assign adv         = (r_state == S_HASH);
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign mod_go      = (r_state == S_MOD) && (!o_valid || i_ready);

    // Mask the hash to the buckets in use
    logic [31:0] mask;
    assign mask = (32'd1 << r_bits) - 32'd1;

    // Reduce the masked hash to a real bucket: a mask for a power-of-two table,
    // else a reciprocal estimate of the quotient and one corrective subtract
    logic [47:0] q_prod;
    logic [31:0] rem, red_bkt;
    assign q_prod  = 48'(r_mh) * 48'(RECIP[31:0]);
    assign rem     = 32'(r_mh) - 32'(r_q) * 32'(NUM_BUCKETS);
    assign red_bkt = IS_POW2 ? (32'(r_mh) & (32'(NUM_BUCKETS) - 32'd1))
                   : ((rem >= 32'(NUM_BUCKETS)) ? rem - 32'(NUM_BUCKETS) : rem);

    // Search the ways read from the bucket
    logic          hit, fr;
    logic [WW-1:0] hw, fw;
    always_comb begin
        hit = 1'b0; fr = 1'b0; hw = '0; fw = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            if (r_rvld[w]) begin
                if (!hit && r_rk[w*64 +: 64] == r_key) begin
                    hit = 1'b1; hw = WW'(w);
                end
            end else if (!fr) begin
                fr = 1'b1; fw = WW'(w);
            end
        end
    end

    // Set the way taken by a put, free the way hit by a delete
    always_comb begin
        vld_upd = r_rvld;
        if (r_op == OP_PUT && !hit && fr) vld_upd[fw] = 1'b1;
        if (r_op == OP_DEL && hit) vld_upd[hw] = 1'b0;
    end

    // Clear, read and write back the bucket memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) mem_vld[r_clr] <= '0;
        if (r_state == S_READ) begin
            r_rk   <= mem_k[r_bkt];
            r_rv   <= mem_v[r_bkt];
            r_rvld <= mem_vld[r_bkt];
        end
        if (mod_go) mem_vld[r_bkt] <= vld_upd;
        if (mod_go && r_op == OP_PUT && !hit && fr) begin
            mem_k[r_bkt][fw*64 +: 64] <= r_key;
            mem_v[r_bkt][fw*64 +: 64] <= r_val;
        end
    end

    // Sequence requests and drive results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_cnt <= '0; r_bits <= 4'd8; o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_bits <= i_cfg_data;
            // Raise a finished result, drop an accepted one
            if (mod_go) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(NUM_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid && o_ready) begin
                    r_op <= i_op; r_key <= i_key; r_val <= i_value;
                    r_cnt <= '0; r_state <= S_HASH;
                end
                S_HASH: begin
                    if (r_cnt == 3'(HL)) begin
                        r_mh <= 16'(hash & mask); r_cnt <= '0; r_state <= S_RED;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_RED: begin
                    if (r_cnt == 3'd0) begin
                        r_q <= q_prod[47:32]; r_cnt <= 3'd1;
                    end else begin
                        r_bkt <= red_bkt[BW-1:0]; r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_MOD;
                S_MOD: if (mod_go) begin
                    o_found       <= (r_op != OP_NOP) && hit;
                    o_read_value  <= (r_op == OP_GET && hit) ? r_rv[hw*64 +: 64] : 64'd0;
                    o_bucket_full <= (r_op == OP_PUT) && !hit && !fr;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_acc_idle, i_clk, i_rst_n, i_valid && o_ready, r_state == S_IDLE)
    `CHK_NEXT(a_mod_out, i_clk, i_rst_n, r_state == S_MOD, o_valid)
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `CHK_IMPL(a_full_put, i_clk, i_rst_n, o_valid && o_bucket_full, !o_found)
endmodule

// ===== design/mhkv_hash.sv =====
// Pipelined MurmurHash3 x86_32 over a 64-bit key, at most one multiply per stage
module mhkv_hash import mhkv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [63:0] i_key,
    output logic [31:0] o_hash
);
    logic [31:0] r_k0, r_k1, r_k0b, r_k1b, r_h1, r_h2, r_f0, r_f1, r_f2;
    logic [31:0] h1pre, h2pre;

    assign h1pre = rotl(HASH_SEED ^ r_k0b, 13);
    assign h2pre = rotl(r_h1 ^ r_k1b, 13);

    // Advance every stage together while the sequencer is in its hash state
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_k0  <= i_key[31:0] * C1;
            r_k1  <= i_key[63:32] * C1;
            r_k0b <= rotl(r_k0, 15) * C2;
            r_k1b <= rotl(r_k1, 15) * C2;
            r_h1  <= h1pre * 32'd5 + C3;
            r_h2  <= h2pre * 32'd5 + C3;
            r_f0  <= (r_h2 ^ 32'd8) ^ ((r_h2 ^ 32'd8) >> 16);
            r_f1  <= r_f0 * F1;
            r_f2  <= (r_f1 ^ (r_f1 >> 13)) * F2;
        end
    end
    assign o_hash = r_f2 ^ (r_f2 >> 16);
endmodule
